FILE: rtl/core/bcm_pkg.sv
// Shared types, constants and register codes of the battery cutoff monitor.
package bcm_pkg;

   // Converter and scaling.
   localparam int ADC_BITS  = 10;
   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 16;
   localparam int PROD_W    = ADC_BITS + GAIN_W;
   localparam int VOLT_W    = PROD_W - GAIN_FRAC;
   localparam int THR_W     = 8;
   localparam int OUT_V_W   = 8;
   localparam int LED_W     = 4;

   // Alarm flash timing, counted in samples.
   localparam int ALARM_HALF_PERIOD = 1024;
   localparam int ALARM_CNT_W       = $clog2(2 * ALARM_HALF_PERIOD);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VOLTAGE_GAIN     = 3'd0,
      REG_LEVEL_FULL       = 3'd1,
      REG_LEVEL_HIGH       = 3'd2,
      REG_LEVEL_MID        = 3'd3,
      REG_LEVEL_LOW        = 3'd4,
      REG_ALARM_STOP_LEVEL = 3'd5,
      REG_SHUTDOWN_LEVEL   = 3'd6
   } csr_reg_type;

   localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd10347;
   localparam logic [THR_W-1:0]  FULL_RESET      = 8'(41 * 3);
   localparam logic [THR_W-1:0]  HIGH_RESET      = 8'(38 * 3);
   localparam logic [THR_W-1:0]  MID_RESET       = 8'(35 * 3);
   localparam logic [THR_W-1:0]  LOW_RESET       = 8'(32 * 3);
   localparam logic [THR_W-1:0]  ALARM_STOP_RESET = 8'(31 * 3);
   localparam logic [THR_W-1:0]  SHUTDOWN_RESET  = 8'(30 * 3);

   // Level LED codes.
   localparam logic [LED_W-1:0] LED_NONE = 4'b0000;
   localparam logic [LED_W-1:0] LED_FULL = 4'b0001;
   localparam logic [LED_W-1:0] LED_HIGH = 4'b0010;
   localparam logic [LED_W-1:0] LED_MID  = 4'b0100;
   localparam logic [LED_W-1:0] LED_LOW  = 4'b1000;

   typedef enum logic [1:0] {
      PH_MONITOR = 2'd0,
      PH_ALARM   = 2'd1,
      PH_BLINK   = 2'd2,
      PH_OFF     = 2'd3
   } phase_type;

   typedef struct packed {
      logic [GAIN_W-1:0] voltage_gain;
      logic [THR_W-1:0]  level_full;
      logic [THR_W-1:0]  level_high;
      logic [THR_W-1:0]  level_mid;
      logic [THR_W-1:0]  level_low;
      logic [THR_W-1:0]  alarm_stop_level;
      logic [THR_W-1:0]  shutdown_level;
   } cfg_type;

   typedef struct packed {
      phase_type              phase;
      logic                   power_latch;
      logic                   buzzer_pin;
      logic                   warning_state;
      logic [LED_W-1:0]       level_state;
      logic [ALARM_CNT_W-1:0] alarm_count;
   } state_type;

endpackage

FILE: rtl/core/bcm_step.sv
// Next-state logic of the cutoff monitor: voltage scaling and the phase machine.
module bcm_step (
   input  bcm_pkg::cfg_type                 cfg,
   input  bcm_pkg::state_type               cur,
   input  logic [bcm_pkg::ADC_BITS-1:0]     sample,
   output bcm_pkg::state_type               nxt,
   output logic [bcm_pkg::OUT_V_W-1:0]      scaled_voltage
);
   import bcm_pkg::*;

   logic [PROD_W-1:0] product;
   logic [VOLT_W-1:0] volt;
   logic [VOLT_W-1:0] thr_full, thr_high, thr_mid, thr_low, thr_stop, thr_shut;

   assign product  = PROD_W'(sample) * PROD_W'(cfg.voltage_gain);
   assign volt     = product[PROD_W-1:GAIN_FRAC];
   assign thr_full = VOLT_W'(cfg.level_full);
   assign thr_high = VOLT_W'(cfg.level_high);
   assign thr_mid  = VOLT_W'(cfg.level_mid);
   assign thr_low  = VOLT_W'(cfg.level_low);
   assign thr_stop = VOLT_W'(cfg.alarm_stop_level);
   assign thr_shut = VOLT_W'(cfg.shutdown_level);

   // Comparisons use the full voltage; only the reported value saturates.
   assign scaled_voltage = (volt > VOLT_W'({OUT_V_W{1'b1}})) ? {OUT_V_W{1'b1}}
                                                              : OUT_V_W'(volt);

   always_comb begin
      nxt = cur;
      unique case (cur.phase)
         PH_MONITOR: begin
            if (volt > thr_low) begin
               nxt.power_latch = 1'b1;
            end
            // With misordered thresholds none of the bands may match, and the
            // lamps then keep what they showed.
            if (volt >= thr_full) begin
               nxt.level_state   = LED_FULL;
               nxt.warning_state = 1'b0;
            end else if (volt >= thr_high && volt < thr_full) begin
               nxt.level_state   = LED_HIGH;
               nxt.warning_state = 1'b0;
            end else if (volt >= thr_mid && volt < thr_high) begin
               nxt.level_state   = LED_MID;
               nxt.warning_state = 1'b0;
            end else if (volt >= thr_low && volt < thr_mid) begin
               nxt.level_state   = LED_LOW;
               nxt.warning_state = 1'b0;
            end else if (volt < thr_low) begin
               nxt.level_state   = LED_NONE;
               nxt.warning_state = 1'b1;
               nxt.power_latch   = 1'b0;
               nxt.alarm_count   = '0;
               nxt.phase         = PH_ALARM;
            end
         end
         PH_ALARM: begin
            if (cur.alarm_count < ALARM_CNT_W'(ALARM_HALF_PERIOD)) begin
               nxt.buzzer_pin    = ~cur.buzzer_pin;
               nxt.warning_state = 1'b0;
            end else begin
               nxt.buzzer_pin    = 1'b0;
               nxt.warning_state = 1'b1;
            end
            if (cur.alarm_count == ALARM_CNT_W'(2 * ALARM_HALF_PERIOD - 1)) begin
               nxt.alarm_count = '0;
            end else begin
               nxt.alarm_count = cur.alarm_count + ALARM_CNT_W'(1);
            end
            if (volt < thr_stop) begin
               nxt.level_state   = LED_NONE;
               nxt.warning_state = 1'b1;
               nxt.phase         = PH_BLINK;
            end
         end
         PH_BLINK: begin
            // The buzzer keeps the level it had when the alarm ended.
            nxt.warning_state = ~cur.warning_state;
            if (volt < thr_shut) begin
               nxt.level_state   = LED_NONE;
               nxt.warning_state = 1'b0;
               nxt.buzzer_pin    = 1'b0;
               nxt.power_latch   = 1'b0;
               nxt.phase         = PH_OFF;
            end
         end
         default: begin
            nxt.level_state   = LED_NONE;
            nxt.warning_state = 1'b0;
            nxt.buzzer_pin    = 1'b0;
            nxt.power_latch   = 1'b0;
            nxt.phase         = PH_OFF;
         end
      endcase
   end

endmodule

FILE: rtl/core/battery_cutoff_monitor_unit.sv
// Top level of the battery cutoff monitor: registers, handshakes and configuration.
//
//   Channel   Direction  Handshake           Carries
//   req_      in         req_valid/ready     one ADC sample per transaction
//   rsp_      out        rsp_valid/ready     lamps, buzzer, power, phase, voltage
//   csr_      in         csr_we only         register index and write data
//
// A sample is taken into the input register, and when it moves on the scaling
// multiply and the phase machine update the state and load the result register;
// one sample can be taken in every cycle while the results are taken. The
// single 10 by 16 bit multiply followed by the threshold compares sets the clock
// period. Reset, synchronous and active high, returns the configuration
// registers to their defaults and the phase machine to monitor with every
// output dark. While the result register holds a transaction that is not
// taken, one further sample waits in the input register and the state does
// not move; req_ready then falls.
module battery_cutoff_monitor_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Sample channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bcm_pkg::ADC_BITS-1:0]      req_adc_sample,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bcm_pkg::LED_W-1:0]         rsp_level_leds,
   output logic                              rsp_warning_lit,
   output logic                              rsp_buzzer_level,
   output logic                              rsp_power_enable,
   output logic [1:0]                        rsp_mode_now,
   output logic [bcm_pkg::OUT_V_W-1:0]       rsp_scaled_voltage,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [bcm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bcm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bcm_pkg::*;

   // Configuration registers.
   cfg_type cfg_ff;

   // Input register.
   logic                smp_vld_ff;
   logic [ADC_BITS-1:0] smp_ff;

   // Phase machine state.
   state_type state_ff;
   state_type state_in;

   // Result register.
   logic               rsp_vld_ff;
   state_type          rsp_state_ff;
   logic [OUT_V_W-1:0] rsp_volt_ff;
   logic [OUT_V_W-1:0] volt_in;

   logic advance;

   // The held sample moves on whenever the result register is empty or is
   // being emptied in this cycle.
   assign advance   = smp_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !smp_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_gain     <= GAIN_RESET;
         cfg_ff.level_full       <= FULL_RESET;
         cfg_ff.level_high       <= HIGH_RESET;
         cfg_ff.level_mid        <= MID_RESET;
         cfg_ff.level_low        <= LOW_RESET;
         cfg_ff.alarm_stop_level <= ALARM_STOP_RESET;
         cfg_ff.shutdown_level   <= SHUTDOWN_RESET;
      end else if (csr_we) begin
         // Indexes beyond the register list are ignored.
         unique case (csr_index)
            REG_VOLTAGE_GAIN:     cfg_ff.voltage_gain     <= csr_wdata;
            REG_LEVEL_FULL:       cfg_ff.level_full       <= csr_wdata[THR_W-1:0];
            REG_LEVEL_HIGH:       cfg_ff.level_high       <= csr_wdata[THR_W-1:0];
            REG_LEVEL_MID:        cfg_ff.level_mid        <= csr_wdata[THR_W-1:0];
            REG_LEVEL_LOW:        cfg_ff.level_low        <= csr_wdata[THR_W-1:0];
            REG_ALARM_STOP_LEVEL: cfg_ff.alarm_stop_level <= csr_wdata[THR_W-1:0];
            REG_SHUTDOWN_LEVEL:   cfg_ff.shutdown_level   <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
      end else if (req_ready) begin
         smp_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         smp_ff <= req_adc_sample;
      end
   end

   bcm_step u_step (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .sample         (smp_ff),
      .nxt            (state_in),
      .scaled_voltage (volt_in)
   );

   // The state moves only when a sample is actually consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff <= state_in;
         rsp_volt_ff  <= volt_in;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_level_leds     = rsp_state_ff.level_state;
   assign rsp_warning_lit    = rsp_state_ff.warning_state;
   assign rsp_buzzer_level   = rsp_state_ff.buzzer_pin;
   assign rsp_power_enable   = rsp_state_ff.power_latch;
   assign rsp_mode_now       = rsp_state_ff.phase;
   assign rsp_scaled_voltage = rsp_volt_ff;

   // At most one level LED is ever lit.
   a_leds_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_level_leds))
      else $error("more than one level LED lit");

   // Once dark, the monitor stays dark until reset.
   a_off_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_OFF |=> state_ff.phase == PH_OFF)
      else $error("phase left off without reset");

   // The load switch can only be on while monitoring.
   a_power_monitor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_enable |-> rsp_mode_now == PH_MONITOR)
      else $error("power enabled outside monitor phase");

   // The state does not move while no sample is consumed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a consumed sample");

endmodule
